[design/lzss_stream_decompressor_top_defines.svh]
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top_defines.svh
// Assertion macros used by the decompressor checker.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LZSSD_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LZSSD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lzssd_pkg.sv]
// ----------------------------------------------------------------------------
// lzssd_pkg
// Constants and controller/datapath interface types for the LZSS decompressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzssd_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_BITS   = 13;
    localparam int LEN_BITS   = 4;
    localparam int MIN_MATCH  = 3;
    localparam int DICT_DEPTH = 1 << POS_BITS;

    // token sizes in bits, flag included
    localparam int LIT_NEED   = 1 + BYTE_W;
    localparam int MATCH_NEED = 1 + POS_BITS + LEN_BITS;

    // bit buffer: an unfinished token plus one fresh byte
    localparam int BUF_W = MATCH_NEED - 1 + BYTE_W;
    localparam int CNT_W = $clog2(BUF_W + 1);

    // bytes left in a match copy
    localparam int MAX_RUN = (1 << LEN_BITS) - 1 + MIN_MATCH;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);

    typedef struct packed {
        logic load_in;      // take the input byte
        logic new_stream;   // renew head, bit buffer and stop flag
        logic decode;       // consume one token from the bit buffer
        logic emit_lit;     // send the literal, store it
        logic rd_issue;     // dictionary read at the copy address
        logic emit_match;   // send the byte read, store it
    } cmd_t;

    typedef struct packed {
        logic stopped;      // end marker seen in this stream
        logic last;         // current byte closes the stream
        logic tok_go;       // a token can be decoded now
        logic tok_lit;      // that token is a literal
        logic tok_stop;     // that token is the end marker
        logic eos;          // token being worked off ends the stream
        logic out_free;     // output register can take a byte
        logic run_final;    // one byte left in the copy
    } sts_t;

endpackage

`default_nettype wire

[design/lzssd_ram.sv]
// ----------------------------------------------------------------------------
// lzssd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/lzssd_ctrl.sv]
// ----------------------------------------------------------------------------
// lzssd_ctrl
// Sequencer: takes bytes, walks tokens, steps match copies byte by byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzssd_ctrl
    import lzssd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_LIT    = 6'b000100,
        S_READ   = 6'b001000,
        S_EMIT   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    // a stopped stream just drops bytes
                    if (!sts.stopped)
                    begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE:
            begin
                if (!sts.tok_go)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.decode = 1'b1;
                    if (sts.tok_lit)
                    begin
                        state_next = S_LIT;
                    end
                    else if (sts.tok_stop)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_LIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_lit = 1'b1;
                    state_next   = sts.eos ? S_DONE : S_DECODE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_match = 1'b1;
                    if (sts.run_final)
                    begin
                        state_next = sts.eos ? S_DONE : S_DECODE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                cmd.new_stream = sts.last;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/lzssd_dpath.sv]
// ----------------------------------------------------------------------------
// lzssd_dpath
// Bit buffer, token fields, dictionary with write head, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzssd_dpath
    import lzssd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   run_last
);

    localparam logic [CNT_W-1:0] LIT_NEED_C   = CNT_W'(LIT_NEED);
    localparam logic [CNT_W-1:0] MATCH_NEED_C = CNT_W'(MATCH_NEED);

    // bit buffer, oldest bit at the MSB, unused bits kept zero
    logic [BUF_W-1:0]    bits_reg,      bits_next;
    logic [CNT_W-1:0]    cnt_reg,       cnt_next;
    logic                last_reg,      last_next;
    logic                stopped_reg,   stopped_next;
    logic [POS_BITS-1:0] head_reg,      head_next;
    logic                wrapped_reg,   wrapped_next;
    logic [POS_BITS-1:0] addr_reg,      addr_next;
    logic [RUN_W-1:0]    run_reg,       run_next;
    logic [BYTE_W-1:0]   lit_reg,       lit_next;
    logic                eos_reg,       eos_next;
    logic                more_reg,      more_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                run_last_reg,  run_last_next;

    logic                flag;
    logic [CNT_W-1:0]    need;
    logic                full;
    logic                tok_go;
    logic                tok_eos;
    logic [BYTE_W-1:0]   tok_lit;
    logic [POS_BITS-1:0] tok_pos;
    logic [LEN_BITS-1:0] tok_len;
    logic [BUF_W-1:0]    rest_bits;
    logic [CNT_W-1:0]    rest_cnt;
    logic                nflag;
    logic [CNT_W-1:0]    nneed;
    logic                next_emits;
    logic [BUF_W-1:0]    append_bits;
    logic                dict_hit;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   dict_byte;
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                out_free;

    // token at the head of the buffer; missing bits read as zero
    assign flag    = bits_reg[BUF_W-1];
    assign need    = flag ? LIT_NEED_C : MATCH_NEED_C;
    assign full    = (cnt_reg >= need);
    assign tok_go  = (cnt_reg != '0) && (full || last_reg);
    assign tok_eos = last_reg && (cnt_reg <= need);
    assign tok_lit = bits_reg[BUF_W-2 -: BYTE_W];
    assign tok_pos = bits_reg[BUF_W-2 -: POS_BITS];
    assign tok_len = bits_reg[BUF_W-2-POS_BITS -: LEN_BITS];

    always_comb
    begin
        if (!full)
        begin
            rest_bits = '0;
        end
        else if (flag)
        begin
            rest_bits = bits_reg << LIT_NEED;
        end
        else
        begin
            rest_bits = bits_reg << MATCH_NEED;
        end
    end

    assign rest_cnt = full ? (cnt_reg - need) : '0;

    // look one token ahead so the final byte of this input can be marked
    assign nflag      = rest_bits[BUF_W-1];
    assign nneed      = nflag ? LIT_NEED_C : MATCH_NEED_C;
    assign next_emits = (rest_cnt != '0) && ((rest_cnt >= nneed) || last_reg) &&
                        (nflag || (rest_bits[BUF_W-2 -: POS_BITS] != '0));

    assign append_bits = bits_reg | ({in_byte, {(BUF_W-BYTE_W){1'b0}}} >> cnt_reg);

    // entries not yet written in this stream read as zero; entry 0 is written
    // last, so head at 0 means all others hold data
    assign dict_hit  = wrapped_reg ||
                       ((addr_reg != '0) && ((head_reg == '0) || (addr_reg < head_reg)));
    assign dict_byte = dict_hit ? ram_rdata : '0;

    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_we    = (cmd.emit_lit || cmd.emit_match) && !eos_reg;
    assign ram_wdata = cmd.emit_lit ? lit_reg : dict_byte;

    lzssd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        stopped_next   = stopped_reg;
        head_next      = head_reg;
        wrapped_next   = wrapped_reg;
        addr_next      = addr_reg;
        run_next       = run_reg;
        lit_next       = lit_reg;
        eos_next       = eos_reg;
        more_next      = more_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;

        if (cmd.load_in)
        begin
            if (stopped_reg)
            begin
                if (in_last)
                begin
                    bits_next    = '0;
                    cnt_next     = '0;
                    stopped_next = 1'b0;
                    head_next    = POS_BITS'(1);
                    wrapped_next = 1'b0;
                end
            end
            else
            begin
                bits_next = append_bits;
                cnt_next  = cnt_reg + CNT_W'(BYTE_W);
                last_next = in_last;
            end
        end

        if (cmd.new_stream)
        begin
            bits_next    = '0;
            cnt_next     = '0;
            stopped_next = 1'b0;
            head_next    = POS_BITS'(1);
            wrapped_next = 1'b0;
        end

        if (cmd.decode)
        begin
            bits_next = rest_bits;
            cnt_next  = rest_cnt;
            lit_next  = tok_lit;
            addr_next = tok_pos;
            eos_next  = tok_eos;
            more_next = !tok_eos && next_emits;
            // a copy cut by the stream end gives its first byte only
            run_next  = tok_eos ? RUN_W'(1) : (RUN_W'(tok_len) + RUN_W'(MIN_MATCH));
            if (!flag && (tok_pos == '0))
            begin
                stopped_next = 1'b1;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_lit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = lit_reg;
            run_last_next  = !more_reg;
        end

        if (cmd.emit_match)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = dict_byte;
            run_last_next  = (run_reg == RUN_W'(1)) && !more_reg;
            addr_next      = addr_reg + POS_BITS'(1);
            run_next       = run_reg - RUN_W'(1);
        end

        if (ram_we)
        begin
            head_next    = head_reg + POS_BITS'(1);
            wrapped_next = wrapped_reg || (head_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
            head_reg      <= POS_BITS'(1);
            wrapped_reg   <= 1'b0;
            run_reg       <= '0;
            eos_reg       <= 1'b0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg      <= bits_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            stopped_reg   <= stopped_next;
            head_reg      <= head_next;
            wrapped_reg   <= wrapped_next;
            run_reg       <= run_next;
            eos_reg       <= eos_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        lit_reg      <= lit_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    assign sts.stopped   = stopped_reg;
    assign sts.last      = last_reg;
    assign sts.tok_go    = tok_go;
    assign sts.tok_lit   = flag;
    assign sts.tok_stop  = !flag && (tok_pos == '0);
    assign sts.eos       = eos_reg;
    assign sts.out_free  = out_free;
    assign sts.run_final = (run_reg == RUN_W'(1));

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

`default_nettype wire

[design/lzss_stream_decompressor_top.sv]
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top
// LZSS stream decompressor: compressed bytes in, decompressed bytes out.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------
//   input   | in        | in_valid/in_stall  | in_byte, in_last
//   output  | out       | out_valid/out_stall| out_byte, run_last
//
// Each input byte is loaded, its tokens are decoded one at a time, then a
// closing step runs; a byte dropped after the end marker is only loaded.
// A literal is decoded, then sent; a match is decoded, then each byte copied
// is read from the dictionary, then sent and written back (up to 18 bytes).
// Reset clears all control state; the dictionary needs no clearing pass,
// the write head and a wrap flag tell which entries hold this stream's data.
// A stalled output holds the block in place; the next input transfer waits
// until all results of the current byte are in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decompressor_top
    import lzssd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   run_last
);

    cmd_t cmd;
    sts_t sts;

    lzssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    lzssd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

[design/lzssd_checker.sv]
// ----------------------------------------------------------------------------
// lzssd_checker
// Port-level checks on the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lzss_stream_decompressor_top_defines.svh"

module lzssd_checker
    import lzssd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [BYTE_W-1:0] in_byte,
    input wire logic              in_last,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [BYTE_W-1:0] out_byte,
    input wire logic              run_last
);

    logic unused_in;
    assign unused_in = in_valid ^ in_last ^ (^in_byte);

    // held output keeps its payload
    `LZSSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last), "stalled output changed")

    // more results of the same byte follow, so no new byte may be taken
    `LZSSD_ASSERT_SAME(a_busy_mid_run, clk, rst_n, out_valid && !run_last, in_stall, "input taken while results remain")

    // a new result is produced only while working on a byte
    `LZSSD_ASSERT_SAME(a_rise_busy, clk, rst_n, $rose(out_valid), in_stall, "result appeared while idle")

    // after a non-final transfer the block is still busy
    `LZSSD_ASSERT_NEXT(a_after_mid, clk, rst_n, out_valid && !out_stall && !run_last, in_stall, "idle before final result")

endmodule

bind lzss_stream_decompressor_top lzssd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
);

`default_nettype wire
